FILE: hdl/aivd_pkg.sv
// Package: shared types, character codes and helper functions of the AIVDM deframer.
`timescale 1ns / 1ps
package aivd_pkg;

  typedef struct packed {
    logic [7:0] char_in;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_out;
    logic [2:0] error_code;
  } out_item_t;

  typedef struct packed {
    logic      has;
    out_item_t item;
  } step_res_t;

  typedef struct packed {
    logic [2:0] field_num;
    logic [2:0] char_pos;
    logic [7:0] run_xor;
    logic       after_star;
    logic [1:0] hex_seen;
    logic [7:0] rx_sum;
    logic [3:0] frag_total;
    logic [3:0] frag_index;
    logic [3:0] line_id;
    logic [3:0] exp_id;
    logic       sent_open;
    logic [2:0] line_err;
  } line_state_t;

  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_FRAGMENT = 2'd1;
  localparam logic [1:0] KIND_COMPLETE = 2'd2;
  localparam logic [1:0] KIND_ERROR    = 2'd3;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_START     = 3'd1;
  localparam logic [2:0] ERR_CHECKSUM  = 3'd2;
  localparam logic [2:0] ERR_HEADER    = 3'd3;
  localparam logic [2:0] ERR_ID        = 3'd4;
  localparam logic [2:0] ERR_MALFORMED = 3'd5;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [3:0] NO_ID = 4'd15;

  // Expected header letter at a field-0 position (1..5 spell AIVDM).
  function automatic logic [7:0] hdr_char(input logic [2:0] pos);
    logic [7:0] ch;
    begin
      unique case (pos)
        3'd1:    ch = 8'h41;
        3'd2:    ch = 8'h49;
        3'd3:    ch = 8'h56;
        3'd4:    ch = 8'h44;
        3'd5:    ch = 8'h4D;
        default: ch = 8'h00;
      endcase
      return ch;
    end
  endfunction

  // Keep the first error of a line.
  function automatic logic [2:0] flag_err(input logic [2:0] cur, input logic [2:0] code);
    return (cur == ERR_NONE) ? code : cur;
  endfunction

endpackage

FILE: hdl/nmea_aivdm_sentence_deframer_unit.sv
// Top level of the AIVDM deframer: request register, line parser and result register.
`timescale 1ns / 1ps
// Path: a character accepted into the request register has its result loaded into the result
// register once that register is empty or being taken; a stalled result holds it back.
// Throughput: one character per cycle; the request register advances whenever
// the result register is empty or being taken.
// Reset: synchronous, active low; clears both valid flags and all parser state.
module nmea_aivdm_sentence_deframer_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  aivd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output aivd_pkg::out_item_t out_data
);

  // Request register: holds one character ahead of the parser.
  logic                in_valid_r;
  aivd_pkg::in_item_t  in_data_r;

  // Result register.
  logic                out_valid_r;
  aivd_pkg::out_item_t out_data_r;

  aivd_pkg::step_res_t step_res;
  logic                advance;

  // Advance the held character when the result register can take a result.
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  // Hold the input only while a character is waiting and cannot move.
  assign in_stall = in_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_data_r <= in_data;
    end
  end

  aivd_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (advance),
    .step_item(in_data_r),
    .step_res (step_res)
  );

  // Load a new result, or drop the old one once it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && step_res.has) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_res.has) begin
      out_data_r <= step_res.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hdl/aivd_core.sv
// Line parser state and per-character update logic of the AIVDM deframer.
`timescale 1ns / 1ps
module aivd_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  aivd_pkg::in_item_t step_item,
  output aivd_pkg::step_res_t step_res
);

  aivd_pkg::line_state_t st_r, st_nxt;
  aivd_pkg::step_res_t   res;
  logic [7:0] c;
  logic       last;
  logic       is_digit;
  logic       is_hex_af;
  logic [7:0] d;
  logic [3:0] hex_v;
  logic [3:0] want;
  logic [2:0] err;

  always_comb begin
    st_nxt    = st_r;
    res       = '0;
    c         = step_item.char_in;
    last      = step_item.line_end;
    is_digit  = (c >= aivd_pkg::CH_ZERO) && (c <= aivd_pkg::CH_NINE);
    is_hex_af = (c >= aivd_pkg::CH_UPPER_A) && (c <= aivd_pkg::CH_UPPER_F);
    d         = c - aivd_pkg::CH_ZERO;
    hex_v     = is_digit ? d[3:0] : (c[3:0] + 4'd9);
    want      = st_r.sent_open ? (st_r.frag_index + 4'd1) : 4'd1;
    err       = aivd_pkg::ERR_NONE;

    if (st_r.field_num == 3'd0 && st_r.char_pos == 3'd0 && !st_r.after_star) begin
      if (c != aivd_pkg::CH_DOLLAR && c != aivd_pkg::CH_BANG)
        st_nxt.line_err = aivd_pkg::flag_err(st_nxt.line_err, aivd_pkg::ERR_START);
      st_nxt.char_pos = 3'd1;
    end else if (st_r.after_star) begin
      if (!is_digit && !is_hex_af) begin
        st_nxt.hex_seen = 2'd3;
      end else if (st_r.hex_seen < 2'd2) begin
        st_nxt.rx_sum   = {st_r.rx_sum[3:0], hex_v};
        st_nxt.hex_seen = st_r.hex_seen + 2'd1;
      end else begin
        st_nxt.hex_seen = 2'd3;
      end
    end else if (c == aivd_pkg::CH_STAR) begin
      st_nxt.after_star = 1'b1;
    end else begin
      st_nxt.run_xor = st_r.run_xor ^ c;
      if (c == aivd_pkg::CH_COMMA) begin
        if (st_r.field_num == 3'd0 && st_r.char_pos != 3'd6)
          st_nxt.line_err = aivd_pkg::flag_err(st_nxt.line_err, aivd_pkg::ERR_HEADER);
        if ((st_r.field_num == 3'd1 || st_r.field_num == 3'd2) && st_r.char_pos == 3'd0)
          st_nxt.line_err = aivd_pkg::flag_err(st_nxt.line_err, aivd_pkg::ERR_MALFORMED);
        if (st_r.field_num != 3'd7)
          st_nxt.field_num = st_r.field_num + 3'd1;
        st_nxt.char_pos = 3'd0;
        if (st_r.field_num == 3'd2)
          st_nxt.line_id = aivd_pkg::NO_ID;
      end else begin
        if (st_r.field_num == 3'd0) begin
          if (st_r.char_pos < 3'd1 || st_r.char_pos > 3'd5 ||
              c != aivd_pkg::hdr_char(st_r.char_pos))
            st_nxt.line_err = aivd_pkg::flag_err(st_nxt.line_err, aivd_pkg::ERR_HEADER);
        end else if (st_r.field_num <= 3'd3) begin
          // Single decimal digit fields: total, index, id.
          if (st_r.char_pos != 3'd0 || !is_digit) begin
            st_nxt.line_err = aivd_pkg::flag_err(st_nxt.line_err, aivd_pkg::ERR_MALFORMED);
          end else if (st_r.field_num == 3'd1) begin
            if (st_r.sent_open && d[3:0] != st_r.frag_total)
              st_nxt.line_err = aivd_pkg::flag_err(st_nxt.line_err, aivd_pkg::ERR_MALFORMED);
            st_nxt.frag_total = d[3:0];
          end else if (st_r.field_num == 3'd2) begin
            if (d[3:0] != want)
              st_nxt.line_err = aivd_pkg::flag_err(st_nxt.line_err, aivd_pkg::ERR_MALFORMED);
            st_nxt.frag_index = d[3:0];
          end else begin
            st_nxt.line_id = d[3:0];
          end
        end else if (st_r.field_num == 3'd5 && !last) begin
          res.has           = 1'b1;
          res.item.kind     = aivd_pkg::KIND_PAYLOAD;
          res.item.char_out = c;
        end
        if (st_r.char_pos != 3'd7)
          st_nxt.char_pos = st_r.char_pos + 3'd1;
      end
    end

    if (last) begin
      if (st_nxt.line_err == aivd_pkg::ERR_START)
        err = aivd_pkg::ERR_START;
      else if (!st_nxt.after_star || st_nxt.hex_seen != 2'd2)
        err = aivd_pkg::ERR_MALFORMED;
      else if (st_nxt.run_xor != st_nxt.rx_sum)
        err = aivd_pkg::ERR_CHECKSUM;
      else if (st_nxt.line_err != aivd_pkg::ERR_NONE)
        err = st_nxt.line_err;
      else if (st_nxt.field_num != 3'd6)
        err = aivd_pkg::ERR_MALFORMED;
      else if (st_nxt.frag_total == 4'd0 || st_nxt.frag_index > st_nxt.frag_total)
        err = aivd_pkg::ERR_MALFORMED;
      else if (st_nxt.sent_open && st_nxt.line_id != st_nxt.exp_id)
        err = aivd_pkg::ERR_ID;

      res = '0;
      res.has = 1'b1;
      if (err != aivd_pkg::ERR_NONE) begin
        res.item.kind       = aivd_pkg::KIND_ERROR;
        res.item.error_code = err;
        st_nxt.sent_open    = 1'b0;
      end else if (st_nxt.frag_index == st_nxt.frag_total) begin
        res.item.kind    = aivd_pkg::KIND_COMPLETE;
        st_nxt.sent_open = 1'b0;
      end else begin
        res.item.kind = aivd_pkg::KIND_FRAGMENT;
        if (!st_nxt.sent_open)
          st_nxt.exp_id = st_nxt.line_id;
        st_nxt.sent_open = 1'b1;
      end
      // Drop per-line collection; fragment bookkeeping survives.
      st_nxt.field_num  = 3'd0;
      st_nxt.char_pos   = 3'd0;
      st_nxt.run_xor    = 8'd0;
      st_nxt.after_star = 1'b0;
      st_nxt.hex_seen   = 2'd0;
      st_nxt.rx_sum     = 8'd0;
      st_nxt.line_err   = aivd_pkg::ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (step_en) begin
      st_r <= st_nxt;
    end
  end

  assign step_res = res;

endmodule

FILE: hdl/aivd_checker.sv
// Port-level checker for the AIVDM deframer and its bind.
`timescale 1ns / 1ps
module aivd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input aivd_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input aivd_pkg::out_item_t out_data
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled request changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != aivd_pkg::KIND_PAYLOAD |-> out_data.char_out == 8'd0)
    else $error("report carries a character");

  a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.kind == aivd_pkg::KIND_ERROR) ==
                   (out_data.error_code != aivd_pkg::ERR_NONE)))
    else $error("error code does not match kind");

  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.error_code <= aivd_pkg::ERR_MALFORMED)
    else $error("error code out of range");

endmodule

bind nmea_aivdm_sentence_deframer_unit aivd_checker u_aivd_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

FILE: tb/tb.sv
// Testbench for the AIVDM sentence deframer: directed and random NMEA lines checked against a cycle-free parser copy.
`timescale 1ns / 1ps
module tb;

  // Handshake timing and run limits.
  localparam int RESET_CYCLES   = 12;
  localparam int HOLD_CYCLES    = 400;   // long receiver hold-off that backs the block up
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no request moving on either side
  localparam int TARGET_CHARS   = 1050;
  localparam int MAX_PRINTS     = 40;

  // Text the header field must carry, one letter per byte, first letter on top.
  localparam logic [39:0] HEADER_WORD = "AIVDM";
  localparam logic [7:0]  CH_LOWER_A  = 8'h61;
  localparam logic [7:0]  CH_LOWER_G  = 8'h67;
  localparam logic [7:0]  CH_UPPER_B  = 8'h42;

  // Receiver stall patterns.
  localparam int RX_OPEN     = 0;
  localparam int RX_SPARSE   = 1;
  localparam int RX_PERIODIC = 2;
  localparam int RX_HEAVY    = 3;

  // Ways a generated fragment line can be broken.
  typedef enum int {
    M_NONE, M_START, M_HEADER, M_TOTAL, M_INDEX, M_ID, M_FIELDS, M_INSERT,
    M_SUM_VALUE, M_SUM_FORM, M_TRUNC
  } flaw_t;

  // Parser copy plus the queue of reports the block still owes.
  class deframe_scoreboard;
    logic [2:0] fld;
    logic [2:0] pos;
    logic [7:0] xsum;
    logic       star_seen;
    logic [1:0] hex_count;
    logic [7:0] rx_csum;
    logic [3:0] frag_tot;
    logic [3:0] frag_idx;
    logic [3:0] line_id;
    logic [3:0] latched_id;
    logic       sent_open;
    logic [2:0] first_err;
    aivd_pkg::out_item_t expected_reports[$];
    int unsigned fails;

    function new();
      clear_line();
      frag_tot   = '0;
      frag_idx   = '0;
      line_id    = '0;
      latched_id = '0;
      sent_open  = 1'b0;
      fails      = 0;
    endfunction

    function void clear_line();
      fld       = '0;
      pos       = '0;
      xsum      = '0;
      star_seen = 1'b0;
      hex_count = '0;
      rx_csum   = '0;
      first_err = aivd_pkg::ERR_NONE;
    endfunction

    function void note_err(logic [2:0] code);
      if (first_err == aivd_pkg::ERR_NONE) first_err = code;
    endfunction

    function void queue_report(aivd_pkg::out_item_t rep);
      expected_reports.insert(expected_reports.size(), rep);
    endfunction

    function logic [7:0] header_letter(logic [2:0] p);
      if (p >= 3'd1 && p <= 3'd5) return HEADER_WORD[8*(5-p) +: 8];
      return 8'h00;
    endfunction

    // Collect one checksum character; anything but 0-9/A-F or a third digit poisons it.
    function void take_hex(logic [7:0] c);
      logic [3:0] v;
      logic       ok;
      ok = 1'b1;
      v  = '0;
      if (c >= aivd_pkg::CH_ZERO && c <= aivd_pkg::CH_NINE)
        v = 4'(c - aivd_pkg::CH_ZERO);
      else if (c >= aivd_pkg::CH_UPPER_A && c <= aivd_pkg::CH_UPPER_F)
        v = 4'(c - aivd_pkg::CH_UPPER_A + 8'd10);
      else ok = 1'b0;
      if (!ok) hex_count = 2'd3;
      else if (hex_count < 2'd2) begin
        rx_csum   = {rx_csum[3:0], v};
        hex_count = hex_count + 2'd1;
      end else hex_count = 2'd3;
    endfunction

    // Total, index and id fields: one decimal digit each.
    function void take_digit(logic [7:0] c);
      logic [3:0] d;
      logic [3:0] want_idx;
      if (pos != 3'd0 || c < aivd_pkg::CH_ZERO || c > aivd_pkg::CH_NINE) begin
        note_err(aivd_pkg::ERR_MALFORMED);
        return;
      end
      d = 4'(c - aivd_pkg::CH_ZERO);
      if (fld == 3'd1) begin
        if (sent_open && d != frag_tot) note_err(aivd_pkg::ERR_MALFORMED);
        frag_tot = d;
      end else if (fld == 3'd2) begin
        want_idx = sent_open ? frag_idx + 4'd1 : 4'd1;
        if (d != want_idx) note_err(aivd_pkg::ERR_MALFORMED);
        frag_idx = d;
      end else begin
        line_id = d;
      end
    endfunction

    // Advance the parser by one character; queue the report it causes, if any.
    function void note_char(aivd_pkg::in_item_t it);
      logic [7:0] c;
      logic [2:0] err;
      aivd_pkg::out_item_t rep;
      logic       has;
      c   = it.char_in;
      has = 1'b0;
      rep = '0;
      if (fld == 3'd0 && pos == 3'd0 && !star_seen) begin
        if (c != aivd_pkg::CH_DOLLAR && c != aivd_pkg::CH_BANG) note_err(aivd_pkg::ERR_START);
        pos = 3'd1;
      end else if (star_seen) begin
        take_hex(c);
      end else if (c == aivd_pkg::CH_STAR) begin
        star_seen = 1'b1;
      end else begin
        xsum ^= c;
        if (c == aivd_pkg::CH_COMMA) begin
          if (fld == 3'd0 && pos != 3'd6) note_err(aivd_pkg::ERR_HEADER);
          if ((fld == 3'd1 || fld == 3'd2) && pos == 3'd0) note_err(aivd_pkg::ERR_MALFORMED);
          if (fld < 3'd7) fld = fld + 3'd1;
          pos = 3'd0;
          if (fld == 3'd3) line_id = aivd_pkg::NO_ID;
        end else begin
          if (fld == 3'd0) begin
            if (pos < 3'd1 || pos > 3'd5 || c != header_letter(pos))
              note_err(aivd_pkg::ERR_HEADER);
          end else if (fld <= 3'd3) begin
            take_digit(c);
          end else if (fld == 3'd5 && !it.line_end) begin
            has          = 1'b1;
            rep.kind     = aivd_pkg::KIND_PAYLOAD;
            rep.char_out = c;
          end
          if (pos < 3'd7) pos = pos + 3'd1;
        end
      end

      if (it.line_end) begin
        err = aivd_pkg::ERR_NONE;
        if (first_err == aivd_pkg::ERR_START) err = aivd_pkg::ERR_START;
        else if (!star_seen || hex_count != 2'd2) err = aivd_pkg::ERR_MALFORMED;
        else if (xsum != rx_csum) err = aivd_pkg::ERR_CHECKSUM;
        else if (first_err != aivd_pkg::ERR_NONE) err = first_err;
        else if (fld != 3'd6) err = aivd_pkg::ERR_MALFORMED;
        else if (frag_tot == 4'd0 || frag_idx > frag_tot) err = aivd_pkg::ERR_MALFORMED;
        else if (sent_open && line_id != latched_id) err = aivd_pkg::ERR_ID;
        has = 1'b1;
        rep = '0;
        if (err != aivd_pkg::ERR_NONE) begin
          rep.kind       = aivd_pkg::KIND_ERROR;
          rep.error_code = err;
          sent_open      = 1'b0;
        end else if (frag_idx == frag_tot) begin
          rep.kind  = aivd_pkg::KIND_COMPLETE;
          sent_open = 1'b0;
        end else begin
          rep.kind = aivd_pkg::KIND_FRAGMENT;
          if (!sent_open) latched_id = line_id;
          sent_open = 1'b1;
        end
        clear_line();
      end
      if (has) queue_report(rep);
    endfunction

    task report_mismatch(string what);
      if (fails < MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, what);
      fails++;
    endtask

    task check_report(aivd_pkg::out_item_t got);
      aivd_pkg::out_item_t want;
      if (expected_reports.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d char %02h code %0d",
                                  got.kind, got.char_out, got.error_code));
        return;
      end
      want = expected_reports.pop_front();
      if (got.kind !== want.kind)
        report_mismatch($sformatf("kind got %0d want %0d", got.kind, want.kind));
      if (got.char_out !== want.char_out)
        report_mismatch($sformatf("char_out got %02h want %02h", got.char_out, want.char_out));
      if (got.error_code !== want.error_code)
        report_mismatch($sformatf("error_code got %0d want %0d",
                                  got.error_code, want.error_code));
    endtask

    function int outstanding();
      return expected_reports.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  aivd_pkg::in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  aivd_pkg::out_item_t out_data;

  deframe_scoreboard sb = new();

  logic [7:0] line_q[$];     // characters of the line being sent
  int         chars_sent = 0;
  int         idle_cycles = 0;
  int         burst_left = 0;
  bit         hold_req = 1'b0;

  // Append one character to the line being built.
  function automatic void add_char(input logic [7:0] c);
    line_q.insert(line_q.size(), c);
  endfunction

  always #1 clk = ~clk;

  nmea_aivdm_sentence_deframer_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Watch both channels at each edge: feed accepted characters to the parser copy,
  // check accepted reports, and count cycles in which nothing moved.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_char(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_report(out_data);
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // End the run if the handshakes stop moving.
  initial begin : watchdog
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: pick a stall pattern for a random stretch; on request, hold off for a
  // long stretch so the block backs up and stalls its input.
  initial begin : receiver
    int mode;
    int stretch;
    int phase;
    mode    = RX_OPEN;
    stretch = 0;
    phase   = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (stretch == 0) begin
          mode    = $urandom_range(RX_OPEN, RX_HEAVY);
          stretch = $urandom_range(5, 60);
        end
        stretch--;
        phase++;
        case (mode)
          RX_OPEN:     out_stall <= 1'b0;
          RX_SPARSE:   out_stall <= ($urandom_range(0, 3) == 0);
          RX_PERIODIC: out_stall <= (phase % 3 == 0);
          default:     out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Offer one character and hold it until accepted; at the end of a burst drop
  // valid for a random gap.
  task automatic push_char(input logic [7:0] c, input logic last);
    int gap;
    in_valid <= 1'b1;
    in_data  <= '{char_in: c, line_end: last};
    do @(posedge clk); while (in_stall);
    chars_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_line();
    for (int i = 0; i < line_q.size(); i++) push_char(line_q[i], i == line_q.size() - 1);
  endtask

  // Stop offering and wait until every queued report has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic load_text(input string s);
    line_q = {};
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    return (v < 4'd10) ? aivd_pkg::CH_ZERO + 8'(v) : aivd_pkg::CH_UPPER_A + 8'(v) - 8'd10;
  endfunction

  function automatic logic [7:0] digit_char(input int d);
    return aivd_pkg::CH_ZERO + 8'(d);
  endfunction

  // Any byte that does not split fields or open the checksum.
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == aivd_pkg::CH_COMMA || b == aivd_pkg::CH_STAR) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // Append '*' and the checksum of everything after the start character.
  task automatic seal_line(input logic [7:0] flip);
    logic [7:0] csum;
    csum = flip;
    for (int i = 1; i < line_q.size(); i++) csum ^= line_q[i];
    add_char(aivd_pkg::CH_STAR);
    add_char(hex_char(csum[7:4]));
    add_char(hex_char(csum[3:0]));
  endtask

  // Build one fragment line; an id of 10 leaves the id field empty.
  task automatic compose_fragment(input int tot, input int idx, input int msg_id,
                                  input flaw_t flaw);
    logic [7:0] b;
    int         n;
    line_q = {};
    add_char($urandom_range(0, 1) ? aivd_pkg::CH_DOLLAR : aivd_pkg::CH_BANG);
    for (int p = 0; p < 5; p++) add_char(HEADER_WORD[8*(4-p) +: 8]);
    if (flaw == M_HEADER) line_q[$urandom_range(1, 5)] = text_byte();
    add_char(aivd_pkg::CH_COMMA);
    if (flaw == M_TOTAL) begin
      case ($urandom_range(0, 4))
        0: ;                                                  // empty total
        1: add_char(aivd_pkg::CH_ZERO);
        2: begin
          add_char(digit_char(tot));
          add_char(digit_char($urandom_range(0, 9)));
        end
        3: add_char(CH_UPPER_B);
        default: add_char(digit_char((tot + $urandom_range(1, 9)) % 10));
      endcase
    end else add_char(digit_char(tot));
    add_char(aivd_pkg::CH_COMMA);
    if (flaw == M_INDEX && $urandom_range(0, 3) == 0) ;       // empty index
    else add_char(digit_char(idx));
    add_char(aivd_pkg::CH_COMMA);
    if (msg_id < 10) add_char(digit_char(msg_id));
    if (flaw == M_ID && $urandom_range(0, 2) == 0) add_char(text_byte());
    add_char(aivd_pkg::CH_COMMA);
    case ($urandom_range(0, 3))
      0: add_char(aivd_pkg::CH_UPPER_A);
      1: add_char(CH_UPPER_B);
      2: ;
      default: add_char(text_byte());
    endcase
    add_char(aivd_pkg::CH_COMMA);
    n = $urandom_range(0, 10);
    repeat (n) add_char(text_byte());
    add_char(aivd_pkg::CH_COMMA);
    add_char(digit_char($urandom_range(0, 5)));
    if (flaw == M_FIELDS) begin
      if ($urandom_range(0, 1)) begin
        void'(line_q.pop_back());
        void'(line_q.pop_back());
      end else begin
        add_char(aivd_pkg::CH_COMMA);
        add_char(aivd_pkg::CH_ZERO);
      end
    end
    if (flaw == M_INSERT)
      line_q.insert($urandom_range(1, line_q.size()), 8'($urandom_range(0, 255)));
    seal_line((flaw == M_SUM_VALUE) ? 8'($urandom_range(1, 255)) : 8'h00);
    if (flaw == M_START) begin
      b = 8'($urandom_range(0, 255));
      while (b == aivd_pkg::CH_DOLLAR || b == aivd_pkg::CH_BANG) b = 8'($urandom_range(0, 255));
      line_q[0] = b;
    end
    if (flaw == M_SUM_FORM) begin
      case ($urandom_range(0, 4))
        0: void'(line_q.pop_back());                          // one digit only
        1: repeat (2) void'(line_q.pop_back());               // star, no digits
        2: repeat (3) void'(line_q.pop_back());               // no checksum at all
        3: add_char(hex_char(4'($urandom_range(0, 15))));     // third digit
        default: line_q[line_q.size() - 1 - $urandom_range(0, 1)] =
                   $urandom_range(0, 1) ? CH_LOWER_A + 8'($urandom_range(0, 5)) :
                                          ($urandom_range(0, 1) ? CH_LOWER_G : text_byte());
      endcase
    end
    if (flaw == M_TRUNC) begin
      n = $urandom_range(1, line_q.size() - 1);
      while (line_q.size() > n) void'(line_q.pop_back());
    end
  endtask

  // One sentence: mostly clean fragments in order, sometimes a broken one,
  // sometimes abandoned halfway.
  task automatic run_sentence();
    int    tot;
    int    msg_id;
    int    line_id;
    int    line_idx;
    flaw_t flaw;
    tot    = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 9) : $urandom_range(1, 3);
    msg_id = $urandom_range(0, 10);
    for (int k = 1; k <= tot; k++) begin
      flaw = M_NONE;
      if ($urandom_range(0, 99) < 22) flaw = flaw_t'($urandom_range(M_START, M_TRUNC));
      line_id = msg_id;
      if (flaw == M_ID) begin
        do line_id = $urandom_range(0, 10); while (line_id == msg_id);
      end
      line_idx = k;
      if (flaw == M_INDEX) begin
        do line_idx = $urandom_range(0, 9); while (line_idx == k);
      end
      compose_fragment(tot, line_idx, line_id, flaw);
      send_line();
      if (flaw != M_NONE && $urandom_range(0, 1)) break;
      if ($urandom_range(0, 29) == 0) break;
    end
  endtask

  initial begin : stimulus
    int  n;
    bit  held;
    bit  paused;
    held   = 1'b0;
    paused = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: bad start on printable and extreme bytes, lines with no
    // checksum, then one clean single-fragment sentence with a payload.
    load_text("X");
    send_line();
    line_q = '{8'h00};
    send_line();
    line_q = '{8'hFF};
    send_line();
    load_text("$");
    send_line();
    load_text("!*");
    send_line();
    load_text("!AIVDM,1,1,,A,P,0");
    seal_line(8'h00);
    send_line();
    wait_drained();

    // Random: mostly sentences, some raw noise lines.
    while (chars_sent < TARGET_CHARS) begin
      if (!held && chars_sent > 300) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      if (!paused && chars_sent > 650) begin
        wait_drained();
        paused = 1'b1;
      end
      if ($urandom_range(0, 6) == 0) begin
        line_q = {};
        n = $urandom_range(1, 8);
        repeat (n) add_char(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1)) line_q[0] = aivd_pkg::CH_DOLLAR;
        send_line();
      end else begin
        run_sentence();
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.fails == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
